@@ rtl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the JSON string unescape block
// Result kinds, error codes and the result group passed to the output stage.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NO_QUOTE   = 4'd0,
        ERR_CONTROL    = 4'd1,
        ERR_TRUNC_ESC  = 4'd2,
        ERR_TRUNC_HEX  = 4'd3,
        ERR_BAD_HEX    = 4'd4,
        ERR_NO_LOW     = 4'd5,
        ERR_BAD_LOW    = 4'd6,
        ERR_STRAY_LOW  = 4'd7,
        ERR_BAD_ESC    = 4'd8,
        ERR_UNTERM     = 4'd9
    } err_t;

    localparam int unsigned MaxResults = 4;

    // Results caused by one input item
    typedef struct packed {
        logic [2:0]                   cnt;
        kind_t                        kind;
        logic [MaxResults-1:0][7:0]   bytes;
        err_t                         err;
    } group_t;

endpackage

@@ rtl/jsu_decode.sv @@
// ----------------------------------------------------------------------------
// jsu_decode: escape decoder and UTF-8 encoder
// Holds the parse state and turns one input item into a group of results.
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic         action,
    input  logic [7:0]   in_byte,
    output group_t       grp
);

    typedef enum logic [2:0] {
        PH_SEEK    = 3'd0,
        PH_BODY    = 3'd1,
        PH_ESC     = 3'd2,
        PH_HEX1    = 3'd3,
        PH_WANT_BS = 3'd4,
        PH_WANT_U  = 3'd5,
        PH_HEX2    = 3'd6
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [15:0]  acc_reg, acc_next;
    logic [1:0]   dcnt_reg, dcnt_next;
    logic [9:0]   hs_reg, hs_next;

    logic         do_fail;
    err_t         fcode;
    logic         do_end;
    logic         emit_b;
    logic [7:0]   byte_v;
    logic         emit_cp;
    logic [20:0]  cp;
    logic [4:0]   hx;
    logic [15:0]  acc_sh;
    logic [20:0]  pair_cp;

    function automatic logic [4:0] hex_of(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66)
            r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46)
            r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    assign hx      = hex_of(in_byte);
    assign acc_sh  = {acc_reg[11:0], hx[3:0]};
    assign pair_cp = 21'h10000 + {1'b0, hs_reg, acc_sh[9:0]};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dcnt_next  = dcnt_reg;
        hs_next    = hs_reg;
        do_fail    = 1'b0;
        fcode      = ERR_NO_QUOTE;
        do_end     = 1'b0;
        emit_b     = 1'b0;
        byte_v     = 8'h00;
        emit_cp    = 1'b0;
        cp         = 21'd0;

        if (action)
        begin
            do_fail = 1'b1;
            unique case (phase_reg)
                PH_BODY:                          fcode = ERR_UNTERM;
                PH_ESC:                           fcode = ERR_TRUNC_ESC;
                PH_HEX1:                          fcode = ERR_TRUNC_HEX;
                PH_WANT_BS, PH_WANT_U, PH_HEX2:   fcode = ERR_NO_LOW;
                default:                          fcode = ERR_NO_QUOTE;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_BODY:
                begin
                    if (in_byte == 8'h22)
                    begin
                        phase_next = PH_SEEK;
                        do_end     = 1'b1;
                    end
                    else if (in_byte < 8'h20)
                    begin
                        do_fail = 1'b1;
                        fcode   = ERR_CONTROL;
                    end
                    else if (in_byte == 8'h5C)
                        phase_next = PH_ESC;
                    else
                    begin
                        emit_b = 1'b1;
                        byte_v = in_byte;
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_BODY;
                    emit_b     = 1'b1;
                    unique case (in_byte)
                        8'h22:   byte_v = 8'h22;
                        8'h5C:   byte_v = 8'h5C;
                        8'h2F:   byte_v = 8'h2F;
                        8'h62:   byte_v = 8'h08;
                        8'h66:   byte_v = 8'h0C;
                        8'h6E:   byte_v = 8'h0A;
                        8'h72:   byte_v = 8'h0D;
                        8'h74:   byte_v = 8'h09;
                        8'h75:
                        begin
                            emit_b     = 1'b0;
                            phase_next = PH_HEX1;
                            acc_next   = 16'h0000;
                            dcnt_next  = 2'd0;
                        end
                        default:
                        begin
                            emit_b  = 1'b0;
                            do_fail = 1'b1;
                            fcode   = ERR_BAD_ESC;
                        end
                    endcase
                end
                PH_HEX1:
                begin
                    if (!hx[4])
                    begin
                        do_fail = 1'b1;
                        fcode   = ERR_BAD_HEX;
                    end
                    else if (dcnt_reg != 2'd3)
                    begin
                        acc_next  = acc_sh;
                        dcnt_next = dcnt_reg + 2'd1;
                    end
                    else
                    begin
                        acc_next  = 16'h0000;
                        dcnt_next = 2'd0;
                        if (acc_sh >= 16'hD800 && acc_sh <= 16'hDBFF)
                        begin
                            hs_next    = acc_sh[9:0];
                            phase_next = PH_WANT_BS;
                        end
                        else if (acc_sh >= 16'hDC00 && acc_sh <= 16'hDFFF)
                        begin
                            do_fail = 1'b1;
                            fcode   = ERR_STRAY_LOW;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                            emit_cp    = 1'b1;
                            cp         = {5'd0, acc_sh};
                        end
                    end
                end
                PH_WANT_BS:
                begin
                    if (in_byte != 8'h5C)
                    begin
                        do_fail = 1'b1;
                        fcode   = ERR_NO_LOW;
                    end
                    else
                        phase_next = PH_WANT_U;
                end
                PH_WANT_U:
                begin
                    if (in_byte != 8'h75)
                    begin
                        do_fail = 1'b1;
                        fcode   = ERR_NO_LOW;
                    end
                    else
                    begin
                        phase_next = PH_HEX2;
                        acc_next   = 16'h0000;
                        dcnt_next  = 2'd0;
                    end
                end
                PH_HEX2:
                begin
                    if (!hx[4])
                    begin
                        do_fail = 1'b1;
                        fcode   = ERR_BAD_HEX;
                    end
                    else if (dcnt_reg != 2'd3)
                    begin
                        acc_next  = acc_sh;
                        dcnt_next = dcnt_reg + 2'd1;
                    end
                    else if (acc_sh < 16'hDC00 || acc_sh > 16'hDFFF)
                    begin
                        do_fail = 1'b1;
                        fcode   = ERR_BAD_LOW;
                    end
                    else
                    begin
                        acc_next   = 16'h0000;
                        dcnt_next  = 2'd0;
                        hs_next    = 10'd0;
                        phase_next = PH_BODY;
                        emit_cp    = 1'b1;
                        cp         = pair_cp;
                    end
                end
                default:
                begin
                    if (in_byte == 8'h20 || (in_byte >= 8'h09 && in_byte <= 8'h0D))
                        phase_next = PH_SEEK;
                    else if (in_byte == 8'h22)
                        phase_next = PH_BODY;
                    else
                    begin
                        do_fail = 1'b1;
                        fcode   = ERR_NO_QUOTE;
                    end
                end
            endcase
        end

        if (do_fail)
        begin
            phase_next = PH_SEEK;
            acc_next   = 16'h0000;
            dcnt_next  = 2'd0;
            hs_next    = 10'd0;
        end
    end

    // Build the result group
    always_comb
    begin
        grp.cnt   = 3'd0;
        grp.kind  = KIND_BYTE;
        grp.bytes = '0;
        grp.err   = ERR_NO_QUOTE;
        if (do_fail)
        begin
            grp.cnt  = 3'd1;
            grp.kind = KIND_ERR;
            grp.err  = fcode;
        end
        else if (do_end)
        begin
            grp.cnt  = 3'd1;
            grp.kind = KIND_END;
        end
        else if (emit_b)
        begin
            grp.cnt      = 3'd1;
            grp.bytes[0] = byte_v;
        end
        else if (emit_cp)
        begin
            if (cp <= 21'h7F)
            begin
                grp.cnt      = 3'd1;
                grp.bytes[0] = cp[7:0];
            end
            else if (cp <= 21'h7FF)
            begin
                grp.cnt      = 3'd2;
                grp.bytes[0] = {3'b110, cp[10:6]};
                grp.bytes[1] = {2'b10, cp[5:0]};
            end
            else if (cp <= 21'hFFFF)
            begin
                grp.cnt      = 3'd3;
                grp.bytes[0] = {4'b1110, cp[15:12]};
                grp.bytes[1] = {2'b10, cp[11:6]};
                grp.bytes[2] = {2'b10, cp[5:0]};
            end
            else
            begin
                grp.cnt      = 3'd4;
                grp.bytes[0] = {5'b11110, cp[20:18]};
                grp.bytes[1] = {2'b10, cp[17:12]};
                grp.bytes[2] = {2'b10, cp[11:6]};
                grp.bytes[3] = {2'b10, cp[5:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            acc_reg   <= 16'h0000;
            dcnt_reg  <= 2'd0;
            hs_reg    <= 10'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            dcnt_reg  <= dcnt_next;
            hs_reg    <= hs_next;
        end
    end

endmodule

@@ rtl/jsu_out_buf.sv @@
// ----------------------------------------------------------------------------
// jsu_out_buf: result register and serialiser
// Holds one result group and sends its items one per cycle while m_axis_tready is high.
// ----------------------------------------------------------------------------
module jsu_out_buf
    import jsu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  group_t        grp,
    output logic          can_load,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [15:0]   m_axis_tdata,   // data_byte[7:0], error_code[11:8], zero
    output logic [1:0]    m_axis_tuser,   // kind[1:0]
    output logic          m_axis_tlast
);

    logic [2:0]       cnt_reg;
    logic [1:0]       idx_reg;
    kind_t            kind_reg;
    logic [3:0][7:0]  bytes_reg;
    err_t             err_reg;
    logic             pop;
    logic             last;

    assign last          = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign m_axis_tvalid = cnt_reg != 3'd0;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign can_load      = !m_axis_tvalid || (pop && last);
    assign m_axis_tdata  = {4'h0, err_reg, bytes_reg[idx_reg]};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else if (can_load)
        begin
            cnt_reg <= load ? grp.cnt : 3'd0;
            idx_reg <= 2'd0;
        end
        else if (pop)
            idx_reg <= idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            kind_reg  <= grp.kind;
            bytes_reg <= grp.bytes;
            err_reg   <= grp.err;
        end
    end

endmodule

@@ rtl/json_string_unescape_top.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_top: streaming JSON string unescape to UTF-8
//
// channel   dir  tdata                        tuser          tlast
// s_axis    in   in_byte[7:0]                 action         -
// m_axis    out  data_byte[7:0], err[11:8]    kind[1:0]      last_of_run
//
// One input item is decoded combinationally between the input register and the
// result register; with at most one result per item the block sustains one item
// per cycle while m_axis_tready is high. An item that gives n results (1 to 4)
// holds the result register until all n have left on the single output port.
// Asynchronous reset returns the parser to seeking a quote and empties both
// registers. The input register takes one further item while results wait on
// m_axis; it then holds it and drops s_axis_tready until the last result leaves.
// ----------------------------------------------------------------------------
module json_string_unescape_top
    import jsu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // in_byte[7:0]
    input  logic          s_axis_tuser,   // action
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [15:0]   m_axis_tdata,   // data_byte[7:0], error_code[11:8], zero
    output logic [1:0]    m_axis_tuser,   // kind[1:0]
    output logic          m_axis_tlast
);

    logic        in_valid_reg;
    logic        in_action_reg;
    logic [7:0]  in_byte_reg;
    logic        can_load;
    logic        fire;
    group_t      grp;

    assign fire          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_action_reg <= s_axis_tuser;
            in_byte_reg   <= s_axis_tdata;
        end
    end

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .action  (in_action_reg),
        .in_byte (in_byte_reg),
        .grp     (grp)
    );

    jsu_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire),
        .grp           (grp),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ERR |-> m_axis_tlast)
        else $error("error item not last of run");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast)
        else $error("end item not last of run");

    a_nonbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tdata[7:0] == 8'h00)
        else $error("data byte set on non-byte item");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !can_load |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input item lost");

endmodule
